FILE: hdl/centered_moving_average_unit_assert.svh
// assertion macros for the centred moving average unit checker
`ifndef CENTERED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define CMA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define CMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cma_pkg.sv
// shared constants and types for the centred moving average unit
package cma_pkg;

  localparam int CMA_MAX_HALF_WIDTH = 31;
  localparam int CMA_SAMPLE_BITS    = 24;

  localparam int VALUE_W = 24;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int TAG_W   = YEAR_W + MONTH_W;
  localparam int CFG_W   = 5;
  localparam int TDATA_W = 48;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: hdl/cma_cell.sv
// one cell of a sample chain: holds an entry and its valid bit, shifts towards cell zero
module cma_cell import cma_pkg::*; #(
  parameter int WIDTH = CMA_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic             take_new,
  input  logic [WIDTH-1:0] new_data,
  input  logic [WIDTH-1:0] nb_data,
  input  logic             nb_valid,
  output logic [WIDTH-1:0] data,
  output logic             valid
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= take_new ? 1'b1 : nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= take_new ? new_data : nb_data;
    end
  end

endmodule

FILE: hdl/cma_divider.sv
// restoring divider, one quotient bit per cycle
module cma_divider #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] steps;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  assign trial    = {rem, quo[NUM_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = (trial >= {1'b0, dvs});
  assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= denom;
      quo <= numer;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/centered_moving_average_unit.sv
// centred moving average with truncated edges over a stream of dated samples
// each beat is taken in the idle state and checked; when cell zero of the date chain holds a date,
// the bit-serial divider forms the mean, which enters the output register once that is free
// a new beat is taken only after the last one is through, so the divider sets the pace; a final
// beat adds h flush steps, each with a result only when the centre holds a date, plus any output stall
// rst is synchronous: window sum, count, valid bits and handshakes clear, chain data does not
module centered_moving_average_unit import cma_pkg::*; #(
  parameter int MAX_HALF_WIDTH = CMA_MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = CMA_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,   // half_width
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // sample_value, sample_year, sample_month
  input  logic               s_axis_tlast,  // is_last
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // mean_value, mean_year, mean_month
  output logic               m_axis_tlast,  // last_out
  output logic               m_axis_tuser   // short_stream
);

  localparam int HW     = $clog2(MAX_HALF_WIDTH + 1);
  localparam int CW     = HW + 1;
  localparam int SUMW   = SAMPLE_BITS + CW;
  localparam int VDEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int TDEPTH = MAX_HALF_WIDTH + 1;
  localparam int PAD_W  = TDATA_W - VALUE_W - TAG_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_OUT   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [HW-1:0]          h;
  logic [HW-1:0]          cfg_h;
  logic [SUMW-1:0]        sum;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_acc;
  logic [HW-1:0]          flush_left;
  logic                   last_pend;
  logic                   short_pend;
  logic                   accept;
  logic                   div_start;
  logic                   div_done;
  logic [SUMW-1:0]        div_quotient;
  logic                   end_stream;
  logic                   out_load;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TAG_W-1:0]       in_tag;
  logic [SUMW-1:0]        popped;
  cell_ctl_t              chain_ctl;

  logic [SAMPLE_BITS-1:0] val_data [VDEPTH+1];
  logic [VDEPTH:0]        val_valid;
  logic [TAG_W-1:0]       tag_data [TDEPTH+1];
  logic [TDEPTH:0]        tag_valid;

  logic [VALUE_W-1:0]     out_mean;
  logic [YEAR_W-1:0]      out_year;
  logic [MONTH_W-1:0]     out_month;
  logic                   out_last;
  logic                   out_short;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_sample     = SAMPLE_BITS'(s_axis_tdata[VALUE_W-1:0]);
  assign in_tag        = s_axis_tdata[VALUE_W +: TAG_W];
  assign popped        = val_valid[0] ? SUMW'(val_data[0]) : '0;
  assign count_acc     = val_valid[0] ? count : count + CW'(1);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign chain_ctl.clear = cfg_wr_en || end_stream;
  assign chain_ctl.shift = accept || (state == ST_FLUSH);

  always_comb begin
    if (int'(cfg_wr_data) > MAX_HALF_WIDTH) begin
      cfg_h = HW'(MAX_HALF_WIDTH);
    end else begin
      cfg_h = HW'(cfg_wr_data);
    end
  end

  // sample chain, new beats enter at cell 2h, cell zero leaves the window
  assign val_data[VDEPTH] = '0;
  assign val_valid[VDEPTH] = 1'b0;

  for (genvar i = 0; i < VDEPTH; i++) begin : g_val
    cma_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (chain_ctl),
      .take_new (accept && (CW'(i) == {h, 1'b0})),
      .new_data (in_sample),
      .nb_data  (val_data[i+1]),
      .nb_valid (val_valid[i+1]),
      .data     (val_data[i]),
      .valid    (val_valid[i])
    );
  end

  // date chain, new beats enter at cell h, cell zero is the centre
  assign tag_data[TDEPTH] = '0;
  assign tag_valid[TDEPTH] = 1'b0;

  for (genvar i = 0; i < TDEPTH; i++) begin : g_tag
    cma_cell #(.WIDTH(TAG_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (chain_ctl),
      .take_new (accept && (HW'(i) == h)),
      .new_data (in_tag),
      .nb_data  (tag_data[i+1]),
      .nb_valid (tag_valid[i+1]),
      .data     (tag_data[i]),
      .valid    (tag_valid[i])
    );
  end

  cma_divider #(.NUM_W(SUMW), .DEN_W(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (sum + SUMW'(count >> 1)),
    .denom    (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    end_stream = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (tag_valid[0]) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (last_pend && (flush_left != '0)) begin
          state_next = ST_FLUSH;
        end else begin
          end_stream = last_pend;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_pend && (flush_left != '0)) begin
            state_next = ST_FLUSH;
          end else begin
            end_stream = last_pend;
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        state_next = ST_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        h <= cfg_h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en || end_stream) begin
      sum        <= '0;
      count      <= '0;
      flush_left <= '0;
      last_pend  <= 1'b0;
      short_pend <= 1'b0;
    end else if (accept) begin
      sum        <= sum + SUMW'(in_sample) - popped;
      count      <= count_acc;
      flush_left <= h;
      last_pend  <= s_axis_tlast;
      short_pend <= s_axis_tlast && (count_acc != {h, 1'b1});
    end else if (state == ST_FLUSH) begin
      sum        <= sum - popped;
      count      <= val_valid[0] ? count - CW'(1) : count;
      flush_left <= flush_left - HW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean  <= VALUE_W'(div_quotient);
      out_year  <= tag_data[0][YEAR_W-1:0];
      out_month <= tag_data[0][TAG_W-1:YEAR_W];
      out_last  <= last_pend && (flush_left == '0);
      out_short <= short_pend && (flush_left == '0);
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_month, out_year, out_mean};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_short;

endmodule

FILE: hdl/cma_checker.sv
// port-level checker for the centred moving average unit, bound to the top level
`include "centered_moving_average_unit_assert.svh"

module cma_checker import cma_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast,
  input logic               m_axis_tuser
);

  // a stalled result beat keeps its contents
  `CMA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result beat changed while stalled")

  // no result beat straight out of reset
  `CMA_ASSERT_SAME(a_reset_empty, $past(rst), !m_axis_tvalid, "result beat valid after reset")

  // one sample at a time
  `CMA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a sample is in work")

  // short stream flag only on the final result
  `CMA_ASSERT_SAME(a_short_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "short stream flag without end of stream")

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the centred moving average unit with a scoreboard class
module tb;
  import cma_pkg::*;

  localparam int RING_DEPTH    = 2 * CMA_MAX_HALF_WIDTH + 2;
  localparam int MAX_MEANS     = 32;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 500;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int PHASE_ITEMS   = 48;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic               last_out;
    logic               short_stream;
  } mean_t;

  class window_mean_tracker;
    logic [VALUE_W-1:0] value_ring [RING_DEPTH];
    logic [YEAR_W-1:0]  year_ring  [RING_DEPTH];
    logic [MONTH_W-1:0] month_ring [RING_DEPTH];
    longint unsigned    run_sum;
    int                 wr_ptr;
    int                 centre_ptr;
    int                 fill;
    int                 half_width;
    mean_t              expected_means [$];
    int                 errors;

    function new();
      half_width = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      run_sum = 0;
      wr_ptr = 0;
      centre_ptr = 0;
      fill = 0;
    endfunction

    function void set_half_width(int hw);
      half_width = hw;
      restart();
    endfunction

    function int back(int i, int d);
      return (i + RING_DEPTH - (d % RING_DEPTH)) % RING_DEPTH;
    endfunction

    function void push_mean(int count);
      mean_t           m;
      longint unsigned rounded;
      rounded = (run_sum + count / 2) / count;
      m.value = rounded[VALUE_W-1:0];
      m.year = year_ring[centre_ptr];
      m.month = month_ring[centre_ptr];
      m.last_out = 1'b0;
      m.short_stream = 1'b0;
      expected_means.push_back(m);
      centre_ptr = (centre_ptr + 1) % RING_DEPTH;
    endfunction

    function void note_sample(sample_t s);
      int span;
      int prior;
      int count;
      int lo;
      int pending;
      int ahead;
      int n;
      span = 2 * half_width + 1;
      prior = fill;
      n = 0;
      if (fill >= span)
        run_sum -= value_ring[back(wr_ptr, span)];
      value_ring[wr_ptr] = s.value;
      year_ring[wr_ptr] = s.year;
      month_ring[wr_ptr] = s.month;
      run_sum += s.value;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      if (fill < RING_DEPTH)
        fill++;
      count = (fill < span) ? fill : span;
      if (prior >= half_width) begin
        push_mean(count);
        n++;
      end
      if (s.last) begin
        lo = back(wr_ptr, count);
        pending = back(wr_ptr, centre_ptr);
        for (int j = 0; j < pending && n < MAX_MEANS; j++) begin
          ahead = back(centre_ptr, lo);
          while (ahead > half_width && count > 1) begin
            run_sum -= value_ring[lo];
            lo = (lo + 1) % RING_DEPTH;
            count--;
            ahead--;
          end
          push_mean(count);
          n++;
        end
        if (n > 0) begin
          expected_means[expected_means.size() - 1].last_out = 1'b1;
          expected_means[expected_means.size() - 1].short_stream = (fill < span);
        end
        restart();
      end
    endfunction

    function void check_mean(mean_t got);
      mean_t want;
      if (expected_means.size() == 0) begin
        $error("result beat with no expected mean waiting");
        errors++;
        return;
      end
      want = expected_means.pop_front();
      if (got.value !== want.value) begin
        $error("mean_value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
      if (got.year !== want.year) begin
        $error("mean_year: expected %0d, got %0d", want.year, got.year);
        errors++;
      end
      if (got.month !== want.month) begin
        $error("mean_month: expected %0d, got %0d", want.month, got.month);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
        errors++;
      end
      if (got.short_stream !== want.short_stream) begin
        $error("short_stream: expected %0d, got %0d", want.short_stream, got.short_stream);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  window_mean_tracker tracker = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  centered_moving_average_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int  hold_left;
    int  stall_left;
    logic ready;
    hold_left = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        ready = 1'b0;
      end else begin
        ready = 1'b1;
      end
      m_axis_tready <= ready;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_mean({m_axis_tdata[VALUE_W-1:0], m_axis_tdata[VALUE_W +: YEAR_W],
                          m_axis_tdata[VALUE_W+YEAR_W +: MONTH_W], m_axis_tlast,
                          m_axis_tuser});
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic sample_t mk_sample(int value, int year, int month, bit last);
    sample_t s;
    s.value = value[VALUE_W-1:0];
    s.year = year[YEAR_W-1:0];
    s.month = month[MONTH_W-1:0];
    s.last = last;
    return s;
  endfunction

  function automatic sample_t rand_sample(bit last);
    sample_t s;
    int      pick;
    pick = $urandom_range(0, 7);
    s.value = (pick == 0) ? '0 : (pick == 1) ? '1 : VALUE_W'($urandom);
    s.year = ($urandom_range(0, 7) == 0) ? YEAR_W'($urandom_range(0, 16383))
                                         : YEAR_W'($urandom_range(0, 9999));
    s.month = ($urandom_range(0, 7) == 0) ? MONTH_W'($urandom_range(0, 15))
                                          : MONTH_W'($urandom_range(1, 12));
    s.last = last;
    return s;
  endfunction

  function automatic int pick_len(int hw);
    int span;
    int pick;
    span = 2 * hw + 1;
    pick = $urandom_range(0, 9);
    if (pick < 2)
      return $urandom_range(1, span);
    if (pick == 2)
      return span;
    return $urandom_range(span + 1, span + 24);
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= TDATA_W'({s.month, s.year, s.value});
    s_axis_tlast <= s.last;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_sample(s);
  endtask

  task automatic send_stream(int len, bit terminate);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(terminate && i == len - 1));
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_half_width(int hw);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CFG_W'(hw);
    tracker.set_half_width(hw);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int sent;
    int used;
    int phase;
    int hw;
    int len;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no window: extremes and out-of-range months
    set_half_width(0);
    send_sample(mk_sample(0, 0, 1, 0));
    send_sample(mk_sample(24'hFFFFFF, 9999, 12, 0));
    send_sample(mk_sample(24'hFFFFFF, 16383, 15, 0));
    send_sample(mk_sample(0, 0, 0, 1));
    // short stream and single-sample stream
    set_half_width(2);
    send_sample(mk_sample(24'hFFFFFF, 2001, 13, 0));
    send_sample(mk_sample(3, 2002, 2, 0));
    send_sample(mk_sample(24'hFFFFFF, 2003, 3, 1));
    send_sample(mk_sample(5, 1999, 6, 1));
    // normal stream with rounding ties and both edges
    set_half_width(1);
    send_sample(mk_sample(1, 1900, 1, 0));
    send_sample(mk_sample(2, 1900, 2, 0));
    send_sample(mk_sample(4, 1900, 3, 0));
    send_sample(mk_sample(7, 1900, 4, 0));
    send_sample(mk_sample(24'hFFFFFF, 1900, 5, 1));
    // register write mid-stream discards the stream
    send_sample(mk_sample(100, 1950, 7, 0));
    send_sample(mk_sample(200, 1950, 8, 0));
    set_half_width(3);
    send_stream(7, 1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: hw = CMA_MAX_HALF_WIDTH;
        1: hw = 0;
        2: hw = 1;
        default: hw = $urandom_range(0, CMA_MAX_HALF_WIDTH);
      endcase
      quiet = (RANDOM_ITEMS - sent <= PHASE_ITEMS);
      set_half_width(hw);
      used = 0;
      if (phase == 0) begin
        hold_req = 1'b1;
        send_stream(70, 1);
        used = 70;
      end
      while (used < PHASE_ITEMS) begin
        len = pick_len(hw);
        send_stream(len, 1);
        used += len;
      end
      if (!quiet && $urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 2 * hw + 1);
        send_stream(len, 0);
        used += len;
      end
      sent += used;
      phase++;
    end

    drain();
    if (tracker.errors == 0 && tracker.expected_means.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
